// ===== rtl/core/pctr_pkg.sv =====
`default_nettype none

package pctr_pkg;

    // Width of the tick counter, which advances only on OP_TICK requests (32 to 64)
    localparam int CountWidth = 64;

    localparam logic [63:0] Low32Mask = 64'h0000_0000_ffff_ffff;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_READ_CTL   = 3'd1,
        OP_WRITE_CTL  = 3'd2,
        OP_READ_TVAL  = 3'd3,
        OP_WRITE_TVAL = 3'd4,
        OP_READ_CVAL  = 3'd5,
        OP_WRITE_CVAL = 3'd6,
        OP_UNUSED     = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        user_mode;
        logic [63:0] write_data;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        access_ok;
        logic        irq_level;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/physical_compare_timer_registers_unit.sv =====
// Flow: a request accepted into the input register is held there until the result
// register is free, then passes through the core into it and waits on m_* for m_ready.
// Throughput: one request per cycle while m_ready takes each result; a register stage in
// front of the state update and a result register behind it, both advancing together.
// Reset (aresetn low, synchronous): counter, compare value, enable, mask,
// pending and user access enable cleared; both pipeline stages emptied.
`default_nettype none

module physical_compare_timer_registers_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic        s_user_mode,
    input  wire logic [63:0] s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_read_data,
    output logic             m_access_ok,
    output logic             m_irq_level
);

    logic              uae_reg;
    logic              in_valid_reg;
    pctr_pkg::req_t    in_req_reg;
    logic              out_valid_reg;
    pctr_pkg::result_t out_res_reg;
    pctr_pkg::result_t core_res;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uae_reg <= 1'b0;
        end else if (cfg_valid) begin
            uae_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= '{opcode: s_opcode, user_mode: s_user_mode,
                            write_data: s_write_data};
        end
    end

    pctr_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .advance            (advance),
        .req                (in_req_reg),
        .user_access_enable (uae_reg),
        .result             (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_res_reg.read_data;
    assign m_access_ok = out_res_reg.access_ok;
    assign m_irq_level = out_res_reg.irq_level;

endmodule

`default_nettype wire

// ===== rtl/core/pctr_core.sv =====
`default_nettype none

module pctr_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire pctr_pkg::req_t   req,
    input  wire logic             user_access_enable,
    output pctr_pkg::result_t     result
);

    logic [pctr_pkg::CountWidth-1:0] tick_count_reg, tick_count_next;
    // always holds tick_count + 1, so the tick compare needs no adder in front
    logic [pctr_pkg::CountWidth-1:0] count_inc_reg, count_inc_next;
    logic [63:0] compare_value_reg, compare_value_next;
    logic        timer_enable_reg, timer_enable_next;
    logic        irq_mask_reg, irq_mask_next;
    logic        pending_reg, pending_next;

    logic [63:0]        count_ext;
    logic [63:0]        count_inc_ext;
    logic [31:0]        tval_diff;
    logic               refused;
    pctr_pkg::opcode_t  op;

    assign op            = pctr_pkg::opcode_t'(req.opcode);
    assign count_ext     = 64'(tick_count_reg);
    assign count_inc_ext = 64'(count_inc_reg);
    assign tval_diff     = compare_value_reg[31:0] - count_ext[31:0];

    always_comb begin
        tick_count_next    = tick_count_reg;
        count_inc_next     = count_inc_reg;
        compare_value_next = compare_value_reg;
        timer_enable_next  = timer_enable_reg;
        irq_mask_next      = irq_mask_reg;
        pending_next       = pending_reg;
        result.read_data   = '0;
        result.access_ok   = 1'b1;

        refused = req.user_mode && !user_access_enable &&
                  (req.opcode != pctr_pkg::OP_TICK) && (req.opcode != pctr_pkg::OP_UNUSED);

        if (refused) begin
            result.access_ok = 1'b0;
        end else begin
            case (op)
                pctr_pkg::OP_TICK: begin
                    tick_count_next = count_inc_reg;
                    count_inc_next  = count_inc_reg + 1'b1;
                    if (timer_enable_reg && (count_inc_ext >= compare_value_reg)) begin
                        pending_next = 1'b1;
                    end
                end
                pctr_pkg::OP_READ_CTL: begin
                    result.read_data = {61'd0, pending_reg, irq_mask_reg, timer_enable_reg};
                end
                pctr_pkg::OP_WRITE_CTL: begin
                    timer_enable_next = req.write_data[0];
                    irq_mask_next     = req.write_data[1];
                    if (!req.write_data[0]) begin
                        pending_next = 1'b0;
                    end
                end
                pctr_pkg::OP_READ_TVAL: begin
                    result.read_data = 64'(tval_diff) & pctr_pkg::Low32Mask;
                end
                pctr_pkg::OP_WRITE_TVAL: begin
                    compare_value_next = count_ext +
                        {{32{req.write_data[31]}}, req.write_data[31:0]};
                    if (timer_enable_reg) begin
                        pending_next = 1'b0;
                    end
                end
                pctr_pkg::OP_READ_CVAL: begin
                    result.read_data = compare_value_reg;
                end
                pctr_pkg::OP_WRITE_CVAL: begin
                    compare_value_next = req.write_data;
                    if (timer_enable_reg) begin
                        pending_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        result.irq_level = timer_enable_next && pending_next && !irq_mask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            count_inc_reg     <= pctr_pkg::CountWidth'(1);
            compare_value_reg <= '0;
            timer_enable_reg  <= 1'b0;
            irq_mask_reg      <= 1'b0;
            pending_reg       <= 1'b0;
        end else if (advance) begin
            tick_count_reg    <= tick_count_next;
            count_inc_reg     <= count_inc_next;
            compare_value_reg <= compare_value_next;
            timer_enable_reg  <= timer_enable_next;
            irq_mask_reg      <= irq_mask_next;
            pending_reg       <= pending_next;
        end
    end

    // pending can only live while the timer is enabled
    a_pending_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> timer_enable_reg)
        else $error("pending set while timer disabled");

    a_inc_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_inc_reg == pctr_pkg::CountWidth'(tick_count_reg + 1'b1))
        else $error("increment shadow out of step with counter");

    a_refused_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && refused |=> $stable(compare_value_reg) && $stable(timer_enable_reg)
            && $stable(irq_mask_reg) && $stable(pending_reg) && $stable(tick_count_reg))
        else $error("refused request changed state");

    a_count_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (req.opcode != pctr_pkg::OP_TICK) |=> $stable(tick_count_reg))
        else $error("counter moved on a register request");

endmodule

`default_nettype wire

// ===== bench/pctr_result_checker.sv =====
`default_nettype none

module pctr_result_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic        s_user_mode,
    input  wire logic [63:0] s_write_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_read_data,
    input  wire logic        m_access_ok,
    input  wire logic        m_irq_level,
    output int               mismatches,
    output int               backlog
);

    // Shadow copy of the timer state
    logic [pctr_pkg::CountWidth-1:0] tick_cnt;
    logic [63:0]           cmp_val;
    logic                  timer_en;
    logic                  irq_msk;
    logic                  pend;
    logic                  user_ok;

    pctr_pkg::result_t awaited[$];

    initial begin
        mismatches = 0;
        backlog    = 0;
    end

    always @(posedge aclk) begin
        logic [63:0]       cnt64;
        logic [63:0]       rd;
        logic              ok;
        pctr_pkg::result_t exp_r;
        if (!aresetn) begin
            tick_cnt = '0;
            cmp_val  = '0;
            timer_en = 1'b0;
            irq_msk  = 1'b0;
            pend     = 1'b0;
            user_ok  = 1'b0;
            awaited.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                user_ok = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                rd = '0;
                ok = 1'b1;
                case (s_opcode)
                    pctr_pkg::OP_TICK: begin
                        tick_cnt = tick_cnt + 1'b1;
                        cnt64    = 64'(tick_cnt);
                        if (timer_en && cnt64 >= cmp_val) begin
                            pend = 1'b1;
                        end
                    end
                    pctr_pkg::OP_READ_CTL, pctr_pkg::OP_WRITE_CTL, pctr_pkg::OP_READ_TVAL,
                    pctr_pkg::OP_WRITE_TVAL, pctr_pkg::OP_READ_CVAL,
                    pctr_pkg::OP_WRITE_CVAL: begin
                        if (s_user_mode && !user_ok) begin
                            ok = 1'b0;
                        end else begin
                            cnt64 = 64'(tick_cnt);
                            case (s_opcode)
                                pctr_pkg::OP_READ_CTL: begin
                                    rd = {61'd0, pend, irq_msk, timer_en};
                                end
                                pctr_pkg::OP_WRITE_CTL: begin
                                    timer_en = s_write_data[0];
                                    irq_msk  = s_write_data[1];
                                    if (!timer_en) begin
                                        pend = 1'b0;
                                    end
                                end
                                pctr_pkg::OP_READ_TVAL: begin
                                    rd = (cmp_val - cnt64) & pctr_pkg::Low32Mask;
                                end
                                pctr_pkg::OP_WRITE_TVAL: begin
                                    cmp_val = cnt64 + {{32{s_write_data[31]}},
                                                       s_write_data[31:0]};
                                    if (timer_en) begin
                                        pend = 1'b0;
                                    end
                                end
                                pctr_pkg::OP_READ_CVAL: begin
                                    rd = cmp_val;
                                end
                                pctr_pkg::OP_WRITE_CVAL: begin
                                    cmp_val = s_write_data;
                                    if (timer_en) begin
                                        pend = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: ;  // unused opcode: no effect
                endcase
                exp_r.read_data = rd;
                exp_r.access_ok = ok;
                exp_r.irq_level = timer_en && pend && !irq_msk;
                awaited.push_back(exp_r);
            end
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: rd=%h ok=%b irq=%b",
                                 m_read_data, m_access_ok, m_irq_level);
                    end
                    mismatches = mismatches + 1;
                end else begin
                    exp_r = awaited.pop_front();
                    if (m_read_data !== exp_r.read_data ||
                        m_access_ok !== exp_r.access_ok ||
                        m_irq_level !== exp_r.irq_level) begin
                        if (mismatches < 10) begin
                            $display("mismatch: exp rd=%h ok=%b irq=%b, got rd=%h ok=%b irq=%b",
                                     exp_r.read_data, exp_r.access_ok, exp_r.irq_level,
                                     m_read_data, m_access_ok, m_irq_level);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        backlog = awaited.size();
    end

endmodule

`default_nettype wire

// ===== bench/tb_physical_compare_timer_registers_unit.sv =====
`default_nettype none

module tb_physical_compare_timer_registers_unit;

    localparam int         StallLimit     = 2000;
    localparam int         RandomPerPhase = 200;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic        cfg_wdata    = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode     = pctr_pkg::OP_TICK;
    logic        s_user_mode  = 1'b0;
    logic [63:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [63:0] m_read_data;
    logic        m_access_ok;
    logic        m_irq_level;

    int          mismatches;
    int          backlog;
    int          snd_idle_pct = 26;
    int          rcv_idle_pct = 63;
    int          quiet_cycles = 0;
    logic [63:0] ticks_sent   = '0;

    always #1 aclk = ~aclk;

    physical_compare_timer_registers_unit u_dut (.*);

    pctr_result_checker u_checker (.*);

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge that takes the request.
    task automatic push_req(input logic [2:0] op, input logic usr, input logic [63:0] wd);
        logic taken;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_user_mode  <= usr;
        s_write_data <= wd;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        if (op == pctr_pkg::OP_TICK) begin
            ticks_sent = ticks_sent + 1;
        end
    endtask

    task automatic set_user_access(input logic v);
        logic taken;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (backlog != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
    endtask

    // Random requests that favour enables and compare values near the count, so pending is reached
    task automatic random_phase(input int n, input int user_pct);
        int          r;
        logic [2:0]  op;
        logic [63:0] wd;
        logic [31:0] near;
        for (int i = 0; i < n; i++) begin
            r  = $urandom_range(99);
            wd = {$urandom, $urandom};
            near = $urandom_range(24);
            if (r < 35) begin
                op = pctr_pkg::OP_TICK;
            end else if (r < 50) begin
                op = pctr_pkg::OP_READ_CTL;
            end else if (r < 60) begin
                op = pctr_pkg::OP_WRITE_CTL;
                wd[0] = ($urandom_range(99) < 80);
            end else if (r < 68) begin
                op = pctr_pkg::OP_READ_TVAL;
            end else if (r < 78) begin
                op = pctr_pkg::OP_WRITE_TVAL;
                if ($urandom_range(99) < 70) begin
                    wd[31:0] = near - 32'd8;
                end
            end else if (r < 85) begin
                op = pctr_pkg::OP_READ_CVAL;
            end else if (r < 95) begin
                op = pctr_pkg::OP_WRITE_CVAL;
                if ($urandom_range(99) < 70) begin
                    wd = ticks_sent + 64'(near) - 64'd8;
                end
            end else begin
                op = pctr_pkg::OP_UNUSED;
            end
            push_req(op, ($urandom_range(99) < user_pct), wd);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // user access still off after reset
        push_req(pctr_pkg::OP_READ_CTL,   1'b0, '0);
        push_req(pctr_pkg::OP_READ_CVAL,  1'b0, '1);
        push_req(pctr_pkg::OP_READ_TVAL,  1'b0, '0);
        push_req(pctr_pkg::OP_TICK,       1'b1, '1);
        push_req(pctr_pkg::OP_WRITE_CVAL, 1'b1, '0);
        push_req(pctr_pkg::OP_READ_CTL,   1'b1, '0);
        push_req(pctr_pkg::OP_UNUSED,     1'b1, '1);
        push_req(pctr_pkg::OP_WRITE_CTL,  1'b0, 64'hffff_ffff_ffff_fffd);
        push_req(pctr_pkg::OP_WRITE_TVAL, 1'b0, 64'h0000_0000_8000_0000);
        push_req(pctr_pkg::OP_READ_TVAL,  1'b0, '0);
        push_req(pctr_pkg::OP_WRITE_TVAL, 1'b0, 64'hffff_ffff_0000_0001);
        push_req(pctr_pkg::OP_TICK,       1'b0, '0);
        push_req(pctr_pkg::OP_READ_CTL,   1'b0, '0);
        push_req(pctr_pkg::OP_READ_TVAL,  1'b0, '0);
        push_req(pctr_pkg::OP_WRITE_TVAL, 1'b0, 64'h0000_0000_7fff_ffff);
        push_req(pctr_pkg::OP_WRITE_CVAL, 1'b0, '1);
        push_req(pctr_pkg::OP_READ_CVAL,  1'b0, '0);
        push_req(pctr_pkg::OP_WRITE_CVAL, 1'b0, '0);
        push_req(pctr_pkg::OP_TICK,       1'b0, '0);
        push_req(pctr_pkg::OP_WRITE_CTL,  1'b0, 64'd3);
        push_req(pctr_pkg::OP_READ_CTL,   1'b0, '0);
        push_req(pctr_pkg::OP_WRITE_CTL,  1'b0, 64'd0);
        push_req(pctr_pkg::OP_TICK,       1'b0, '0);
        push_req(pctr_pkg::OP_WRITE_CTL,  1'b0, 64'd1);
        push_req(pctr_pkg::OP_WRITE_TVAL, 1'b0, '1);
        push_req(pctr_pkg::OP_TICK,       1'b0, '0);

        for (int mode = 0; mode < 3; mode++) begin
            snd_idle_pct <= (mode == 0) ? 26 : (mode == 1) ? 63 : 0;
            rcv_idle_pct <= (mode == 0) ? 63 : (mode == 1) ? 26 : 0;
            set_user_access(1'b1);
            random_phase(RandomPerPhase, 50);
            set_user_access(1'b0);
            random_phase(RandomPerPhase, 20);
        end

        s_valid <= 1'b0;
        @(negedge aclk);
        while (backlog != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && backlog == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/pctr_pkg.sv
rtl/core/pctr_core.sv
rtl/core/physical_compare_timer_registers_unit.sv
bench/pctr_result_checker.sv
bench/tb_physical_compare_timer_registers_unit.sv
